[hw/rtl/pb64x_pkg.sv]
`timescale 1ns / 1ps

package pb64x_pkg;

  // One result item as it sits in the output queue
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       image_end;
    logic       marker_missing;
  } res_t;

  // Base64 sextet lookup result
  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  localparam logic [7:0] QuoteChar = 8'h22;
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] SlashChar = 8'h2F;
  localparam logic [5:0] PlusVal   = 6'd62;
  localparam logic [5:0] SlashVal  = 6'd63;

  // Marker letters; entries past the word are zero
  function automatic logic [7:0] marker_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h70; // p
      4'd1:    ch = 8'h61; // a
      4'd2:    ch = 8'h79; // y
      4'd3:    ch = 8'h6C; // l
      4'd4:    ch = 8'h6F; // o
      4'd5:    ch = 8'h61; // a
      4'd6:    ch = 8'h64; // d
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Map a character to its standard base64 value
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == PlusChar) begin
      s.value = PlusVal;
    end else if (c == SlashChar) begin
      s.value = SlashVal;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

[hw/rtl/payload_base64_extractor.sv]
`timescale 1ns / 1ps

// Scans a character stream for the marker word ("payload" by default), skips
// one character, waits for a double quote and then decodes unpadded base64
// into bytes until the first non-base64 character or the end of the message.
// Every message (tlast on the input) ends with one closing transfer that has
// tlast set and reports in tuser whether the marker or quote was missed.
// The block takes one character per clock: the up to four results of each
// character go into an eight-entry output queue. s_axis_tready drops only
// while that queue holds more than four entries, so with the output side
// ready the rate is one character per cycle (four characters give at most
// three bytes, one byte leaves per cycle).
module payload_base64_extractor #(
  parameter int unsigned MARKER_LEN = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_char
  input  logic       s_axis_tlast_i,   // end_of_message
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] data_byte
  output logic       m_axis_tlast_o,   // image_end
  output logic [1:0] m_axis_tuser_o    // [0] has_byte, [1] marker_missing
);
  import pb64x_pkg::*;

  localparam int MatchW = (MARKER_LEN > 1) ? $clog2(MARKER_LEN) : 1;
  localparam int CntW   = MatchW + 1;
  localparam int Depth  = 8;
  localparam int PtrW   = $clog2(Depth);
  localparam int FillW  = PtrW + 1;
  localparam int MaxRes = 4;

  localparam logic [2:0] PhSearch = 3'd0;
  localparam logic [2:0] PhSkip   = 3'd1;
  localparam logic [2:0] PhQuote  = 3'd2;
  localparam logic [2:0] PhDecode = 3'd3;
  localparam logic [2:0] PhDone   = 3'd4;

  logic [2:0]        phase_q, phase_d;
  logic [MatchW-1:0] match_q, match_d;
  logic [17:0]       grp_q, grp_d;
  logic [1:0]        gcnt_q, gcnt_d;

  logic [PtrW-1:0]   wr_q, rd_q;
  logic [FillW-1:0]  fill_q, fill_d;
  res_t              mem_q [Depth];

  logic              in_acc, out_acc;
  res_t              res [MaxRes];
  logic [2:0]        n_res;

  logic [CntW-1:0]   match_inc;
  sextet_t           sx;
  logic [17:0]       fl_grp;
  logic [1:0]        fl_cnt;
  logic [7:0]        byte_v [3];
  logic [1:0]        n_byte;
  logic              miss;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (fill_q <= FillW'(Depth - MaxRes));

  assign match_inc = {1'b0, match_q} + CntW'(1);
  assign sx        = sextet_of(s_axis_tdata_i);

  // Advance the scan state and collect the results of one character
  always_comb begin
    phase_d = phase_q;
    match_d = match_q;
    grp_d   = grp_q;
    gcnt_d  = gcnt_q;
    fl_grp  = grp_q;
    fl_cnt  = 2'd0;
    n_byte  = 2'd0;
    byte_v[0] = 8'h00;
    byte_v[1] = 8'h00;
    byte_v[2] = 8'h00;
    miss    = 1'b0;

    unique case (phase_q)
      PhSearch: begin
        if (s_axis_tdata_i == marker_char(4'(match_q))) begin
          if (match_inc == CntW'(MARKER_LEN)) begin
            match_d = '0;
            phase_d = PhSkip;
          end else begin
            match_d = match_inc[MatchW-1:0];
          end
        end else if (s_axis_tdata_i == marker_char(4'd0)) begin
          // Retry this character as the first marker letter
          if (MARKER_LEN == 1) begin
            match_d = '0;
            phase_d = PhSkip;
          end else begin
            match_d = MatchW'(1);
          end
        end else begin
          match_d = '0;
        end
      end
      PhSkip: phase_d = PhQuote;
      PhQuote: begin
        if (s_axis_tdata_i == QuoteChar) phase_d = PhDecode;
      end
      PhDecode: begin
        if (!sx.valid) begin
          fl_grp  = grp_q;
          fl_cnt  = gcnt_q;
          grp_d   = '0;
          gcnt_d  = 2'd0;
          phase_d = PhDone;
        end else if (gcnt_q == 2'd3) begin
          byte_v[0] = grp_q[17:10];
          byte_v[1] = {grp_q[9:2]};
          byte_v[2] = {grp_q[1:0], sx.value};
          n_byte    = 2'd3;
          grp_d     = '0;
          gcnt_d    = 2'd0;
        end else begin
          grp_d  = {grp_q[11:0], sx.value};
          gcnt_d = gcnt_q + 2'd1;
        end
      end
      default: ;
    endcase

    // Message end: flush a partial group still being decoded
    if (s_axis_tlast_i) begin
      miss = (phase_d == PhSearch) || (phase_d == PhSkip) || (phase_d == PhQuote);
      if (phase_d == PhDecode) begin
        fl_grp = grp_d;
        fl_cnt = gcnt_d;
      end
    end

    // Partial group gives one byte for two sextets, two for three
    if (fl_cnt == 2'd2) begin
      byte_v[0] = fl_grp[11:4];
      n_byte    = 2'd1;
    end else if (fl_cnt == 2'd3) begin
      byte_v[0] = fl_grp[17:10];
      byte_v[1] = fl_grp[9:2];
      n_byte    = 2'd2;
    end

    if (s_axis_tlast_i) begin
      phase_d = PhSearch;
      match_d = '0;
      grp_d   = '0;
      gcnt_d  = 2'd0;
    end
  end

  // Lay the byte items out in order, closing item after them
  always_comb begin
    for (int i = 0; i < MaxRes; i++) begin
      res[i] = '0;
      if (i < 3 && 2'(i) < n_byte) begin
        res[i].data_byte = byte_v[(i < 3) ? i : 0];
        res[i].has_byte  = 1'b1;
      end else if (2'(i) == n_byte && i < MaxRes) begin
        res[i].image_end      = 1'b1;
        res[i].marker_missing = miss;
      end
    end
    n_res = {1'b0, n_byte} + {2'b00, s_axis_tlast_i};
  end

  // Track queue occupancy
  always_comb begin
    fill_d = fill_q;
    if (in_acc) fill_d = fill_d + FillW'(n_res);
    if (out_acc) fill_d = fill_d - FillW'(1);
  end

  // Update scan state and queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSearch;
      match_q <= '0;
      grp_q   <= '0;
      gcnt_q  <= 2'd0;
      wr_q    <= '0;
      rd_q    <= '0;
      fill_q  <= '0;
    end else begin
      if (in_acc) begin
        phase_q <= phase_d;
        match_q <= match_d;
        grp_q   <= grp_d;
        gcnt_q  <= gcnt_d;
        wr_q    <= wr_q + PtrW'(n_res);
      end
      if (out_acc) rd_q <= rd_q + PtrW'(1);
      fill_q <= fill_d;
    end
  end

  // Write the results of an accepted character into the queue
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MaxRes; i++) begin
        if (3'(i) < n_res) mem_q[wr_q + PtrW'(i)] <= res[i];
      end
    end
  end

  // Present the queue head
  assign m_axis_tvalid_o = (fill_q != '0);
  assign m_axis_tdata_o  = mem_q[rd_q].data_byte;
  assign m_axis_tlast_o  = mem_q[rd_q].image_end;
  assign m_axis_tuser_o  = {mem_q[rd_q].marker_missing, mem_q[rd_q].has_byte};

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(Depth))
    else $error("output queue overfilled");

  a_close_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (!m_axis_tuser_o[0] && m_axis_tdata_o == 8'h00))
    else $error("closing transfer carries a byte");

  a_msg_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=> (phase_q == PhSearch && gcnt_q == 2'd0 && match_q == '0))
    else $error("scan state not cleared after message end");

  a_grp_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gcnt_q != 2'd0) |-> (phase_q == PhDecode))
    else $error("partial group held outside decoding");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
  import pb64x_pkg::*;

  localparam int unsigned MarkerLen = 7;
  localparam int unsigned RandomChars = 200;
  localparam logic [7:0] MarkerWord [0:15] = '{
    8'h70, 8'h61, 8'h79, 8'h6C, 8'h6F, 8'h61, 8'h64, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef enum logic [2:0] {
    PH_SEARCH, PH_SKIP, PH_QUOTE, PH_DECODE, PH_DONE
  } scan_phase_e;

  typedef enum int {
    MSG_NOISE, MSG_PARTIAL_MARKER, MSG_NO_QUOTE, MSG_GOOD
  } msg_kind_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [1:0] m_tuser;

  payload_base64_extractor #(
    .MARKER_LEN(MarkerLen)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast),
    .m_axis_tuser_o (m_tuser)
  );

  // Clock and a one-time reset
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  // Predictor state, a copy of the block's scanner
  scan_phase_e decode_phase = PH_SEARCH;
  int unsigned marker_hits = 0;
  logic [17:0] sextet_acc = '0;
  int unsigned sextet_cnt = 0;
  res_t        expected_bytes[$];

  int unsigned err_count = 0;
  int unsigned chars_sent = 0;
  int unsigned msgs_sent = 0;
  int unsigned bytes_seen = 0;
  int unsigned closes_seen = 0;
  int unsigned misses_seen = 0;
  int unsigned burst_left = 0;

  function automatic int sextet_val(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - "A";
    if (c >= "a" && c <= "z") return int'(c) - "a" + 26;
    if (c >= "0" && c <= "9") return int'(c) - "0" + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  function automatic logic [7:0] base64_char(input int unsigned idx);
    if (idx < 26) return 8'(idx + "A");
    if (idx < 52) return 8'(idx - 26 + "a");
    if (idx < 62) return 8'(idx - 52 + "0");
    if (idx == 62) return "+";
    return "/";
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    res_t r;
    r.data_byte      = b;
    r.has_byte       = 1'b1;
    r.image_end      = 1'b0;
    r.marker_missing = 1'b0;
    expected_bytes.push_back(r);
  endfunction

  // Emit what a partial group holds and clear it
  function automatic void flush_group();
    if (sextet_cnt == 2) begin
      push_byte(sextet_acc[11:4]);
    end else if (sextet_cnt == 3) begin
      push_byte(sextet_acc[17:10]);
      push_byte(sextet_acc[9:2]);
    end
    sextet_acc = '0;
    sextet_cnt = 0;
  endfunction

  // Advance the scanner by one character and queue the results it gives
  function automatic void predict_char(input logic [7:0] c, input logic last);
    int v;
    logic [23:0] w;
    res_t close_r;
    case (decode_phase)
      PH_SEARCH: begin
        if (c == MarkerWord[marker_hits]) begin
          marker_hits++;
        end else begin
          marker_hits = (c == MarkerWord[0]) ? 1 : 0;
        end
        if (marker_hits >= MarkerLen) begin
          marker_hits = 0;
          decode_phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        decode_phase = PH_QUOTE;
      end
      PH_QUOTE: begin
        if (c == QuoteChar) decode_phase = PH_DECODE;
      end
      PH_DECODE: begin
        v = sextet_val(c);
        if (v < 0) begin
          flush_group();
          decode_phase = PH_DONE;
        end else if (sextet_cnt == 3) begin
          w = {sextet_acc, 6'(v)};
          push_byte(w[23:16]);
          push_byte(w[15:8]);
          push_byte(w[7:0]);
          sextet_acc = '0;
          sextet_cnt = 0;
        end else begin
          sextet_acc = {sextet_acc[11:0], 6'(v)};
          sextet_cnt++;
        end
      end
      default: ;
    endcase

    // Message end: flush, close, then start over
    if (last) begin
      close_r.data_byte      = 8'h00;
      close_r.has_byte       = 1'b0;
      close_r.image_end      = 1'b1;
      close_r.marker_missing = (decode_phase == PH_SEARCH || decode_phase == PH_SKIP ||
                                decode_phase == PH_QUOTE);
      if (decode_phase == PH_DECODE) flush_group();
      expected_bytes.push_back(close_r);
      decode_phase = PH_SEARCH;
      marker_hits  = 0;
      sextet_acc   = '0;
      sextet_cnt   = 0;
    end
  endfunction

  // Send one character; the sender runs in bursts with gaps in between
  task automatic send_char(input logic [7:0] c, input logic last);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    predict_char(c, last);
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    chars_sent++;
    if (last) msgs_sent++;
    burst_left--;
    if (burst_left == 0) s_tvalid <= 1'b0;
  endtask

  task automatic send_str(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], last_at_end && (i == s.len() - 1));
    end
  endtask

  // Hold the sender and let every expected result come out
  task automatic wait_drain();
    if (burst_left != 0) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
    end
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: the ready pattern switches between random stall modes
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  logic        next_ready;
  res_t        got_r;
  res_t        want_r;

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v,
               act_v);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      got_r.data_byte      = m_tdata;
      got_r.has_byte       = m_tuser[0];
      got_r.image_end      = m_tlast;
      got_r.marker_missing = m_tuser[1];
      if (expected_bytes.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $realtime, got_r);
        err_count++;
      end else begin
        want_r = expected_bytes.pop_front();
        check_field("data_byte", want_r.data_byte, got_r.data_byte);
        check_field("has_byte", want_r.has_byte, got_r.has_byte);
        check_field("image_end", want_r.image_end, got_r.image_end);
        check_field("marker_missing", want_r.marker_missing, got_r.marker_missing);
        if (got_r.has_byte) bytes_seen++;
        if (got_r.image_end) closes_seen++;
        if (got_r.marker_missing) misses_seen++;
      end
    end

    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_mode)
      0:       next_ready = 1'b1;
      1:       next_ready = $urandom_range(0, 1);
      2:       next_ready = ($urandom_range(0, 3) == 0);
      default: next_ready = stall_left[0];
    endcase
    m_tready <= next_ready;
  end

  // Marker retry on a repeated first letter, quote as the skipped character,
  // extreme base64 values, full group at message end is not needed here:
  // lone partial character and then a non-base64 stop with ignored tail
  task automatic test_retry_groups_and_stop();
    send_str("ppayload\"\"+/09AZazQ", 1'b0);
    send_char(8'hFF, 1'b0);
    send_str("x", 1'b1);
  endtask

  // Single-character messages with the marker never seen
  task automatic test_no_marker();
    send_char(8'h00, 1'b1);
    send_char(8'h70, 1'b1);
  endtask

  // End of message inside a group: three characters flush two bytes,
  // then a full group at the end gives the most results per character
  task automatic test_end_inside_group();
    send_str("payload-\"TWE", 1'b1);
    send_str("payload:\"TWFu", 1'b1);
  endtask

  // Random messages, mostly well formed with random content
  task automatic test_random_messages();
    logic [7:0]  msg[$];
    logic [7:0]  c;
    msg_kind_e   kind;
    int unsigned n;
    int unsigned start_chars;
    bit          paused;
    string       decoy;
    start_chars = chars_sent;
    paused = 1'b0;
    while (chars_sent - start_chars < RandomChars) begin
      msg.delete();
      case ($urandom_range(0, 9))
        0:       kind = MSG_NOISE;
        1:       kind = MSG_PARTIAL_MARKER;
        2:       kind = MSG_NO_QUOTE;
        default: kind = MSG_GOOD;
      endcase

      // Leading noise, sometimes with a decoy that breaks off
      repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom_range(0, 255)));
      if (kind == MSG_PARTIAL_MARKER || $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, MarkerLen - 1);
        for (int i = 0; i < n; i++) msg.push_back(MarkerWord[i]);
        msg.push_back(8'($urandom_range(0, 255)));
      end

      if (kind == MSG_NO_QUOTE || kind == MSG_GOOD) begin
        for (int i = 0; i < MarkerLen; i++) msg.push_back(MarkerWord[i]);
        msg.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) begin
          do c = 8'($urandom_range(0, 255)); while (c == QuoteChar);
          msg.push_back(c);
        end
      end

      if (kind == MSG_GOOD) begin
        msg.push_back(QuoteChar);
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 14);
        repeat (n) msg.push_back(base64_char($urandom_range(0, 63)));
        // Stop on a non-base64 character, or let the message end decide
        if (n == 0 || $urandom_range(0, 1) == 0) begin
          do c = 8'($urandom_range(0, 255)); while (sextet_val(c) >= 0);
          msg.push_back(c);
          repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom_range(0, 255)));
        end
      end

      if (msg.size() == 0) msg.push_back(8'($urandom_range(0, 255)));
      foreach (msg[i]) send_char(msg[i], i == msg.size() - 1);

      // Pause once mid-run until the output side has caught up
      if (!paused && chars_sent - start_chars >= RandomChars / 2) begin
        wait_drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_retry_groups_and_stop();
    test_no_marker();
    test_end_inside_group();
    wait_drain();
    test_random_messages();

    wait_drain();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d characters in %0d messages under random gaps and stalls.",
             chars_sent, msgs_sent);
    $display("Checked %0d decoded bytes and %0d closing items (%0d without marker).",
             bytes_seen, closes_seen, misses_seen);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
